### hdl/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int CENTER_W        = 10;
    localparam int PIX_W           = 12;
    localparam int RADIUS_BITS_DEF = 9;
    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 32;

    // Register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS_X = 2'd2,
        REG_RADIUS_Y = 2'd3
    } cfg_reg_t;

    // Position of a pixel within the four reflections of one step
    localparam logic [1:0] EMIT_FIRST = 2'd0;
    localparam logic [1:0] EMIT_LAST  = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_SQ,
        OP_INIT_PROD,
        OP_INIT_DEC,
        OP_R2_SQ,
        OP_R2_PROD,
        OP_R2_DEC,
        OP_STEP,
        OP_DEC
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       region2;
        logic       load;
        logic [1:0] emit_idx;
        logic       emit_done;
    } dp_cmd_t;

    typedef struct packed {
        logic slope_lt;
        logic y_zero;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/mer_req_if.sv
// Request channel: one restart/advance request per handshake.
interface mer_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

### hdl/mer_res_if.sv
// Result channel: one pixel (or done marker) per handshake.
interface mer_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [mer_pkg::PIX_W-1:0] pixel_x;
    logic signed [mer_pkg::PIX_W-1:0] pixel_y;
    logic                            last;
    logic                            done_res;

    modport source (output valid, output pixel_x, output pixel_y, output last,
                    output done_res, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last,
                    input done_res, output ready);
endinterface

### hdl/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer: config registers, FSM and datapath.
//
//  Channel  Dir  Handshake        Payload
//  -------  ---  ---------------  -----------------------------------------
//  req      in   valid/ready      restart (1 = new ellipse, 0 = advance)
//  res      out  valid/ready      pixel_x, pixel_y (s12), last, done_res
//  apb      in   psel/penable     center_x/y, radius_x/y (write and read)
//
//  Sequence: a request is taken only in idle. An advance runs the step and
//  decision update (S_STEP, S_DEC), then emits four pixels; entering region
//  2 first runs the multiplies S_R2_SQ, S_R2_PROD and S_R2_DEC; restart runs
//  S_INIT_SQ, S_INIT_PROD and S_INIT_DEC, then four emits; a done request
//  emits one result. Stalls on res hold the emit sequence; the output
//  register lets the next request in while the last pixel still waits.
//  Reset (rst_n, async low): idle, curve finished, all config zero.
module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mer_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mer_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mer_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    mer_req_if.sink                          req,
    mer_res_if.source                        res
);
    import mer_pkg::*;

    logic [CENTER_W-1:0]    center_x_reg, center_y_reg;
    logic [RADIUS_BITS-1:0] radius_x_reg, radius_y_reg;
    logic                   cfg_wr;
    cfg_reg_t               cfg_sel;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Config port: write lands on the access phase, no wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= '0;
            radius_y_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_CENTER_X: center_x_reg <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[CENTER_W-1:0];
                REG_RADIUS_X: radius_x_reg <= pwdata[RADIUS_BITS-1:0];
                REG_RADIUS_Y: radius_y_reg <= pwdata[RADIUS_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_CENTER_X: prdata = APB_DATA_W'(center_x_reg);
            REG_CENTER_Y: prdata = APB_DATA_W'(center_y_reg);
            REG_RADIUS_X: prdata = APB_DATA_W'(radius_x_reg);
            REG_RADIUS_Y: prdata = APB_DATA_W'(radius_y_reg);
            default:      prdata = '0;
        endcase
    end

    // Sequencer: decides region, step and emission order
    mer_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .status (status),
        .cmd    (cmd)
    );

    // Arithmetic and the result register; centers are read live per pixel
    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .radius_x (radius_x_reg),
        .radius_y (radius_y_reg),
        .status   (status),
        .res      (res)
    );

    // A taken request always starts work: the FSM leaves idle
    a_req_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted but controller stayed idle");

    // The result register is only loaded when it is empty or draining
    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> status.out_free)
        else $error("result register overwritten while stalled");

    // A done result closes its request
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.done_res |-> res.last)
        else $error("done result without last");

    // No request is taken in the middle of a four-pixel group
    a_no_req_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && !cmd.emit_done && cmd.emit_idx != EMIT_LAST |=> !req.ready)
        else $error("request window opened before group finished");

endmodule

### hdl/mer_ctrl.sv
// Controller FSM: sequences setup, midpoint step and pixel emission.
module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    mer_req_if.sink             req,
    input  mer_pkg::dp_status_t status,
    output mer_pkg::dp_cmd_t    cmd
);
    import mer_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_SQ,
        S_INIT_PROD,
        S_INIT_DEC,
        S_R2_SQ,
        S_R2_PROD,
        S_R2_DEC,
        S_STEP,
        S_DEC,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       r2_reg, r2_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       dmode_reg, dmode_next;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        r2_next    = r2_reg;
        cnt_next   = cnt_reg;
        dmode_next = dmode_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.restart)
                    begin
                        state_next = S_INIT_SQ;
                        fin_next   = 1'b0;
                        r2_next    = 1'b0;
                    end
                    else if (fin_reg)
                    begin
                        state_next = S_EMIT;
                        dmode_next = 1'b1;
                    end
                    else if (!r2_reg && status.slope_lt)
                    begin
                        state_next = S_STEP;
                    end
                    else if (!r2_reg)
                    begin
                        state_next = S_R2_SQ;
                    end
                    else if (status.y_zero)
                    begin
                        fin_next   = 1'b1;
                        state_next = S_EMIT;
                        dmode_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_INIT_SQ:   state_next = S_INIT_PROD;
            S_INIT_PROD: state_next = S_INIT_DEC;
            S_INIT_DEC:
            begin
                state_next = S_EMIT;
                dmode_next = 1'b0;
            end
            S_R2_SQ:     state_next = S_R2_PROD;
            S_R2_PROD:   state_next = S_R2_DEC;
            S_R2_DEC:
            begin
                r2_next = 1'b1;
                if (status.y_zero)
                begin
                    fin_next   = 1'b1;
                    state_next = S_EMIT;
                    dmode_next = 1'b1;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:      state_next = S_DEC;
            S_DEC:
            begin
                state_next = S_EMIT;
                dmode_next = 1'b0;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    if (dmode_reg || cnt_reg == EMIT_LAST)
                    begin
                        state_next = S_IDLE;
                        cnt_next   = EMIT_FIRST;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b1;
            r2_reg    <= 1'b0;
            cnt_reg   <= EMIT_FIRST;
            dmode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            r2_reg    <= r2_next;
            cnt_reg   <= cnt_next;
            dmode_reg <= dmode_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_INIT_SQ:   cmd.op = OP_INIT_SQ;
            S_INIT_PROD: cmd.op = OP_INIT_PROD;
            S_INIT_DEC:  cmd.op = OP_INIT_DEC;
            S_R2_SQ:     cmd.op = OP_R2_SQ;
            S_R2_PROD:   cmd.op = OP_R2_PROD;
            S_R2_DEC:    cmd.op = OP_R2_DEC;
            S_STEP:      cmd.op = OP_STEP;
            S_DEC:       cmd.op = OP_DEC;
            default:     cmd.op = OP_NONE;
        endcase
        cmd.region2   = r2_reg;
        cmd.load      = (state_reg == S_EMIT) && status.out_free;
        cmd.emit_idx  = cnt_reg;
        cmd.emit_done = dmode_reg;
    end

endmodule

### hdl/mer_datapath.sv
// Datapath: squared terms, slope terms, decision value and pixel output register.
module mer_datapath #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mer_pkg::dp_cmd_t              cmd,
    input  logic [mer_pkg::CENTER_W-1:0]  center_x,
    input  logic [mer_pkg::CENTER_W-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0]        radius_x,
    input  logic [RADIUS_BITS-1:0]        radius_y,
    output mer_pkg::dp_status_t           status,
    mer_res_if.source                     res
);
    import mer_pkg::*;

    localparam int OW   = RADIUS_BITS + 1;
    localparam int SQW  = 2 * RADIUS_BITS;
    localparam int SW   = 3 * RADIUS_BITS + 3;
    localparam int TXW  = OW + 1;
    localparam int TX2W = 2 * TXW;
    localparam int TYW  = OW + 1;
    localparam int TY2W = 2 * OW;
    localparam int PAW  = SQW + TX2W;
    localparam int PBW  = SQW + TY2W;
    localparam int PCW  = 2 * SQW;
    localparam int DW   = 4 * RADIUS_BITS + 6;
    localparam int XW   = (OW > PIX_W) ? OW : PIX_W;

    logic [OW-1:0]        x_reg, y_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [DW-1:0] d_reg;
    logic [SQW-1:0]       rxs_reg, rys_reg;
    logic [TX2W-1:0]      sqa_reg;
    logic [TY2W-1:0]      sqb_reg;
    logic [PAW-1:0]       pa_reg;
    logic [PBW-1:0]       pb_reg;
    logic [PCW-1:0]       pc_reg;
    logic                 br_reg;

    logic                    out_valid_reg;
    logic signed [PIX_W-1:0] px_reg, py_reg;
    logic                    last_reg, done_reg;

    logic [TXW-1:0]          tx;
    logic signed [TYW-1:0]   ty;
    logic signed [2*TYW-1:0] ty_sq;
    logic [SQW-1:0]          pc_opnd;
    logic [PCW-1:0]          pc_prod;
    logic [SQW-1:0]          rx_sq, ry_sq;
    logic [TX2W-1:0]         tx_sq;
    logic [PAW-1:0]          pa_prod;
    logic [PBW-1:0]          pb_prod;
    logic signed [SW-1:0]    rys2, rxs2, sx_inc, sy_dec;
    logic                    d_neg, d_pos;
    logic [SQW-1:0]          base_u;
    logic signed [SW+1:0]    term;
    logic signed [DW-1:0]    d_init, d_r2, d_upd;
    logic [XW-1:0]           cx_w, cy_w, ox_w, oy_w, pxs, pys;

    // Multipliers, one per registered product
    assign rx_sq   = radius_x * radius_x;
    assign ry_sq   = radius_y * radius_y;
    assign tx      = {x_reg, 1'b1};
    assign tx_sq   = tx * tx;
    assign ty      = $signed({1'b0, y_reg}) - TYW'(1);
    assign ty_sq   = ty * ty;
    assign pc_opnd = (cmd.op == OP_INIT_PROD) ? SQW'(radius_y) : rys_reg;
    assign pc_prod = rxs_reg * pc_opnd;
    assign pa_prod = rys_reg * sqa_reg;
    assign pb_prod = rxs_reg * sqb_reg;

    assign rys2   = $signed(SW'({rys_reg, 1'b0}));
    assign rxs2   = $signed(SW'({rxs_reg, 1'b0}));
    assign sx_inc = sx_reg + rys2;
    assign sy_dec = sy_reg - rxs2;
    assign d_neg  = d_reg[DW-1];
    assign d_pos  = !d_neg && (d_reg != '0);

    // 4*ry^2 - 4*rx^2*ry + rx^2
    assign d_init = ($signed(DW'(rys_reg)) <<< 2) - ($signed(DW'(pc_reg)) <<< 2)
                  + $signed(DW'(rxs_reg));
    // ry^2*(2x+1)^2 + 4*rx^2*(y-1)^2 - 4*rx^2*ry^2
    assign d_r2   = $signed(DW'(pa_reg)) + ($signed(DW'(pb_reg)) <<< 2)
                  - ($signed(DW'(pc_reg)) <<< 2);

    // Decision increment; br_reg tells whether the second axis also moved
    always_comb
    begin
        base_u = cmd.region2 ? rxs_reg : rys_reg;
        term   = $signed({2'b00, SW'(base_u)});
        if (cmd.region2)
        begin
            term = term - {{2{sy_reg[SW-1]}}, sy_reg};
            if (br_reg)
                term = term + {{2{sx_reg[SW-1]}}, sx_reg};
        end
        else
        begin
            term = term + {{2{sx_reg[SW-1]}}, sx_reg};
            if (br_reg)
                term = term - {{2{sy_reg[SW-1]}}, sy_reg};
        end
    end
    assign d_upd = d_reg + ($signed(DW'(term)) <<< 2);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_INIT_SQ:
            begin
                rxs_reg <= rx_sq;
                rys_reg <= ry_sq;
            end
            OP_INIT_PROD:
            begin
                pc_reg <= pc_prod;
            end
            OP_INIT_DEC:
            begin
                x_reg  <= '0;
                y_reg  <= OW'(radius_y);
                sx_reg <= '0;
                sy_reg <= $signed(SW'(pc_reg) << 1);
                d_reg  <= d_init;
            end
            OP_R2_SQ:
            begin
                sqa_reg <= tx_sq;
                sqb_reg <= ty_sq[TY2W-1:0];
            end
            OP_R2_PROD:
            begin
                pa_reg <= pa_prod;
                pb_reg <= pb_prod;
                pc_reg <= pc_prod;
            end
            OP_R2_DEC:
            begin
                d_reg <= d_r2;
            end
            OP_STEP:
            begin
                if (cmd.region2)
                begin
                    y_reg  <= y_reg - OW'(1);
                    sy_reg <= sy_dec;
                    br_reg <= !d_pos;
                    if (!d_pos)
                    begin
                        x_reg  <= x_reg + OW'(1);
                        sx_reg <= sx_inc;
                    end
                end
                else
                begin
                    x_reg  <= x_reg + OW'(1);
                    sx_reg <= sx_inc;
                    br_reg <= !d_neg;
                    if (!d_neg)
                    begin
                        y_reg  <= y_reg - OW'(1);
                        sy_reg <= sy_dec;
                    end
                end
            end
            OP_DEC:
            begin
                d_reg <= d_upd;
            end
            default:
            begin
            end
        endcase
    end

    assign status.slope_lt = (sx_reg < sy_reg);
    assign status.y_zero   = (y_reg == '0);
    assign status.out_free = !out_valid_reg || res.ready;

    // Reflection: index bit 0 negates x, bit 1 negates y
    assign cx_w = XW'(center_x);
    assign cy_w = XW'(center_y);
    assign ox_w = XW'(x_reg);
    assign oy_w = XW'(y_reg);
    assign pxs  = cmd.emit_idx[0] ? (cx_w - ox_w) : (cx_w + ox_w);
    assign pys  = cmd.emit_idx[1] ? (cy_w - oy_w) : (cy_w + oy_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (cmd.emit_done)
            begin
                px_reg   <= '0;
                py_reg   <= '0;
                last_reg <= 1'b1;
                done_reg <= 1'b1;
            end
            else
            begin
                px_reg   <= $signed(pxs[PIX_W-1:0]);
                py_reg   <= $signed(pys[PIX_W-1:0]);
                last_reg <= (cmd.emit_idx == EMIT_LAST);
                done_reg <= 1'b0;
            end
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.pixel_x  = px_reg;
    assign res.pixel_y  = py_reg;
    assign res.last     = last_reg;
    assign res.done_res = done_reg;

endmodule
